>>> rtl/rtcee_pkg.sv
// Package for the Eastern-time epoch clock: sequencer states, calendar constants
// and small calendar helper functions.
// Used by rtcee_div, rtc_epoch_eastern_calendar and rtcee_checker; depends on nothing.
`default_nettype none
package rtcee_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned TpsW    = 24;
  localparam int unsigned EpochW  = 32;
  localparam int unsigned DivW    = 17;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 88;

  localparam logic [CmdW-1:0] CmdTick  = 2'd0;
  localparam logic [CmdW-1:0] CmdSet   = 2'd1;
  localparam logic [CmdW-1:0] CmdRead  = 2'd2;
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;

  localparam logic [TpsW-1:0]   TpsReset    = 24'd1000000;
  localparam logic [DivW-1:0]   SecsPerDay  = 17'd86400;
  localparam logic [DivW-1:0]   SixtyDiv    = 17'd60;
  localparam logic [EpochW-1:0] DstOffset   = 32'd14400;
  localparam logic [EpochW-1:0] StdOffset   = 32'd18000;
  localparam logic [DivW-1:0]   DstStartSod = 17'd25200;
  localparam logic [DivW-1:0]   DstEndSod   = 17'd21600;
  localparam logic [11:0]       BaseYear    = 12'd1970;
  localparam logic [11:0]       NoLeapCentury = 12'd2100;
  localparam logic [2:0]        BaseDow     = 3'd4;

  // Reciprocals of 675 (the day length over 128) scaled by 2^35 and of 15
  // (sixty over four) scaled by 2^19, exact over the operand ranges used.
  localparam logic [25:0]       DayRecip    = 26'd50903317;
  localparam logic [15:0]       SixtyRecip  = 16'd34953;

  typedef enum logic [3:0] {
    StIdle,
    StDivDays,
    StYear,
    StDst,
    StMonth,
    StDivMin,
    StDivHour,
    StFinish
  } state_e;

  typedef struct packed {
    logic             start;
    logic [EpochW-1:0] dividend;
    logic             by_day;
  } div_req_t;

  // The year never leaves 1970 to 2106, so 2100 is the only century that
  // breaks the four-year rule.
  function automatic logic is_leap(input logic [11:0] yr);
    is_leap = (yr[1:0] == 2'b00) && (yr != NoLeapCentury);
  endfunction

  function automatic logic [8:0] month_days(input logic [3:0] mon, input logic leap);
    case (mon)
      4'd2: month_days = leap ? 9'd29 : 9'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_days = 9'd30;
      default: month_days = 9'd31;
    endcase
  endfunction

  function automatic logic [2:0] mod7_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    mod7_add = (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/rtcee_div.sv
// Divider by the day length or by sixty through reciprocal multiplication on one
// shared multiplier: the quotient is registered first, then the remainder.
// Depends on rtcee_pkg.
`default_nettype none
module rtcee_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rtcee_pkg::div_req_t       req_i,
  output logic                           done_o,
  output logic [rtcee_pkg::EpochW-1:0]   quot_o,
  output logic [rtcee_pkg::DivW-1:0]     rem_o
);
  import rtcee_pkg::*;

  logic [EpochW-1:0] num_q;
  logic              day_q;
  logic              mul_q, fix_q, done_q;
  logic [DaysW-1:0]  quo_q, quo_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [24:0]       mul_a;
  logic [25:0]       mul_b;
  logic [50:0]       prod;

  always_comb begin
    if (fix_q) begin
      mul_a = {9'd0, quo_q};
      mul_b = day_q ? {9'd0, SecsPerDay} : {9'd0, SixtyDiv};
    end else if (day_q) begin
      mul_a = num_q[EpochW-1:7];
      mul_b = DayRecip;
    end else begin
      mul_a = {10'd0, num_q[16:2]};
      mul_b = {10'd0, SixtyRecip};
    end
    prod = {26'd0, mul_a} * {25'd0, mul_b};
    quo_d = day_q ? prod[50:35] : {4'd0, prod[30:19]};
    rem_d = num_q[DivW-1:0] - prod[DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= 1'b0;
      fix_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q <= req_i.start;
      fix_q <= mul_q;
      done_q <= fix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      day_q <= req_i.by_day;
    end
    if (mul_q) begin
      quo_q <= quo_d;
    end
    if (fix_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = {16'd0, quo_q};
  assign rem_o = rem_q;

endmodule
`default_nettype wire

>>> rtl/rtc_epoch_eastern_calendar.sv
// Top level of the epoch clock with US Eastern calendar readout.
// Depends on rtcee_pkg and rtcee_div.
//
// Channel  | Dir | Payload
// s_axis   | in  | tuser: cmd; tdata: epoch_value
// m_axis   | out | tuser: time_valid; tdata: UTC epoch and local calendar fields
// cfg      | in  | ticks_per_second, written when cfg_we_i is high
//
// Tick and set transactions are applied when accepted. A read runs through two
// divisions by the day length, two year walks of up to 136 steps, a month walk
// of up to 11 steps and two divisions by sixty, all on one shared multiplier and
// one compare-subtract step. After reset the time is not set and a read returns
// all zeros. Input is not ready while a read is in progress or while a finished
// read waits for the output register to empty.
`default_nettype none
module rtc_epoch_eastern_calendar (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rtcee_pkg::TpsW-1:0]      cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: epoch_value[31:0], zero pad [39:32]
  input  wire logic [rtcee_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: cmd[1:0]
  input  wire logic [rtcee_pkg::CmdW-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: utc_epoch[31:0], local_year[43:32], local_month[47:44],
  // local_day[52:48], local_hour[57:53], local_minute[63:58],
  // local_second[69:64], dst_active[70], minute_of_day[81:71], zero pad [87:82]
  output logic [rtcee_pkg::OutDataW-1:0]       m_axis_tdata,
  // tuser: time_valid
  output logic                                 m_axis_tuser
);
  import rtcee_pkg::*;

  state_e state_q, state_d;
  logic [TpsW-1:0]   tps_q;
  logic              set_q;
  logic [EpochW-1:0] secs_q;
  logic [TpsW-1:0]   sub_q;
  logic              pass_q, valid_q, dst_q;
  logic [DaysW-1:0]  days_q;
  logic [DivW-1:0]   sod_q;
  logic [11:0]       yr_q;
  logic [2:0]        dow_q;
  logic [3:0]        mon_q;
  logic [10:0]       mod_q;
  logic [5:0]        sec_q, min_q;
  logic [4:0]        hour_q;
  logic              mv_q;
  logic [OutDataW-1:0] md_q;
  logic              mu_q;

  div_req_t          div_req;
  logic              div_done;
  logic [EpochW-1:0] div_quot;
  logic [DivW-1:0]   div_rem;

  logic              accept, leap, year_fits, month_fits, dst_now, out_free;
  logic [8:0]        year_len, mon_len, doy, start_d, end_d;
  logic [2:0]        mar_dow;
  logic [3:0]        first_sun;
  logic [TpsW-1:0]   tick_next;

  rtcee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !mv_q || m_axis_tready;
  assign leap = is_leap(yr_q);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign year_fits = days_q < {7'd0, year_len};
  assign mon_len = month_days(mon_q, leap);
  assign month_fits = (mon_q == 4'd12) || (days_q < {7'd0, mon_len});
  assign tick_next = sub_q + 24'd1;

  // March 1 and November 1 share a weekday in every year.
  assign mar_dow = mod7_add(dow_q, 3'd3 + {2'b00, leap});
  assign first_sun = (mar_dow == 3'd0) ? 4'd1 : (4'd8 - {1'b0, mar_dow});
  assign doy = days_q[8:0];
  assign start_d = 9'd65 + {8'd0, leap} + {5'd0, first_sun};
  assign end_d = 9'd303 + {8'd0, leap} + {5'd0, first_sun};
  assign dst_now = ((doy > start_d) || ((doy == start_d) && (sod_q >= DstStartSod))) &&
                   ((doy < end_d) || ((doy == end_d) && (sod_q < DstEndSod)));

  always_comb begin
    state_d = state_q;
    s_axis_tready = 1'b0;
    div_req = '0;
    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (accept && (s_axis_tuser == CmdRead)) begin
          if (set_q) begin
            div_req.start = 1'b1;
            div_req.dividend = secs_q;
            div_req.by_day = 1'b1;
            state_d = StDivDays;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StDivDays: begin
        if (div_done) begin
          state_d = StYear;
        end
      end
      StYear: begin
        if (year_fits) begin
          state_d = pass_q ? StMonth : StDst;
        end
      end
      StDst: begin
        div_req.start = 1'b1;
        div_req.dividend = secs_q - (dst_now ? DstOffset : StdOffset);
        div_req.by_day = 1'b1;
        state_d = StDivDays;
      end
      StMonth: begin
        if (month_fits) begin
          div_req.start = 1'b1;
          div_req.dividend = {15'd0, sod_q};
          div_req.by_day = 1'b0;
          state_d = StDivMin;
        end
      end
      StDivMin: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.dividend = {21'd0, div_quot[10:0]};
          div_req.by_day = 1'b0;
          state_d = StDivHour;
        end
      end
      StDivHour: begin
        if (div_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tps_q <= TpsReset;
      set_q <= 1'b0;
      secs_q <= '0;
      sub_q <= '0;
      mv_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (accept && (s_axis_tuser == CmdTick)) begin
        if ((tick_next >= tps_q) || (tick_next == '0)) begin
          sub_q <= '0;
          secs_q <= secs_q + 32'd1;
        end else begin
          sub_q <= tick_next;
        end
      end
      if (accept && (s_axis_tuser == CmdSet)) begin
        secs_q <= s_axis_tdata[EpochW-1:0];
        sub_q <= '0;
        set_q <= 1'b1;
      end
      if (accept) begin
        pass_q <= 1'b0;
      end else if (state_q == StDst) begin
        pass_q <= 1'b1;
      end
      if ((state_q == StFinish) && out_free) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      valid_q <= set_q;
    end
    if ((state_q == StDivDays) && div_done) begin
      days_q <= div_quot[DaysW-1:0];
      sod_q <= div_rem;
      yr_q <= BaseYear;
      dow_q <= BaseDow;
      mon_q <= 4'd1;
    end
    if ((state_q == StYear) && !year_fits) begin
      days_q <= days_q - {7'd0, year_len};
      yr_q <= yr_q + 12'd1;
      dow_q <= mod7_add(dow_q, {2'b00, leap} + 3'd1);
    end
    if (state_q == StDst) begin
      dst_q <= dst_now;
    end
    if ((state_q == StMonth) && !month_fits) begin
      days_q <= days_q - {7'd0, mon_len};
      mon_q <= mon_q + 4'd1;
    end
    if ((state_q == StDivMin) && div_done) begin
      mod_q <= div_quot[10:0];
      sec_q <= div_rem[5:0];
    end
    if ((state_q == StDivHour) && div_done) begin
      hour_q <= div_quot[4:0];
      min_q <= div_rem[5:0];
    end
    if ((state_q == StFinish) && out_free) begin
      mu_q <= valid_q;
      if (valid_q) begin
        md_q <= {6'd0, mod_q, dst_q, sec_q, min_q, hour_q, 5'(days_q + 16'd1),
                 mon_q, yr_q, secs_q};
      end else begin
        md_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata = md_q;
  assign m_axis_tuser = mu_q;

endmodule
`default_nettype wire

>>> rtl/rtcee_checker.sv
// Port-level checks for the Eastern-time epoch clock, bound to its top level.
// Depends on rtcee_pkg and rtc_epoch_eastern_calendar.
`default_nettype none
module rtcee_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [rtcee_pkg::CmdW-1:0]      s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [rtcee_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire logic                            m_axis_tuser
);
  import rtcee_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output transaction dropped while stalled.");

  a_unset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("Result without valid time carries nonzero fields.");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[47:44] >= 4'd1) && (m_axis_tdata[47:44] <= 4'd12) &&
      (m_axis_tdata[52:48] >= 5'd1) && (m_axis_tdata[57:53] <= 5'd23) &&
      (m_axis_tdata[81:71] <= 11'd1439))
    else $error("Local date or time field out of range.");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CmdRead) |=> !s_axis_tready)
    else $error("Input ready right after a read transaction.");

endmodule

bind rtc_epoch_eastern_calendar rtcee_checker u_rtcee_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
